>>> design/ftca_pkg.sv
package ftca_pkg;

   localparam int TimeWidth   = 48;
   localparam int RegWidth    = 24;
   localparam int LimWidth    = 13;
   localparam int GainWidth   = 16;
   localparam int AngleWidth  = 16;
   localparam int FinWidth    = 14;
   localparam int VelWidth    = 25;
   localparam int MulWidth    = 22;
   localparam int ProdWidth   = 2 * MulWidth;
   localparam int CsrIdxWidth = 2;

   // control modes
   localparam logic [1:0] MODE_MISSION = 2'd0;
   localparam logic [1:0] MODE_REMOTE  = 2'd1;
   localparam logic [1:0] MODE_DEAD    = 2'd2;

   // command sources
   localparam logic [1:0] SRC_AUTO    = 2'd0;
   localparam logic [1:0] SRC_REMOTE  = 2'd1;
   localparam logic [1:0] SRC_RELEASE = 2'd2;

   localparam logic OP_COMMAND = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] REG_REMOTE_TIMEOUT = 2'd0;
   localparam logic [CsrIdxWidth-1:0] REG_COMMAND_PERIOD = 2'd1;
   localparam logic [CsrIdxWidth-1:0] REG_MAX_FIN_ANGLE  = 2'd2;
   localparam logic [CsrIdxWidth-1:0] REG_TOP_FIN_GAIN   = 2'd3;

   localparam logic [RegWidth-1:0]  RESET_REMOTE_TIMEOUT = 24'd2000000;
   localparam logic [RegWidth-1:0]  RESET_COMMAND_PERIOD = 24'd100000;
   localparam logic [LimWidth-1:0]  RESET_MAX_FIN_ANGLE  = 13'd2859;
   localparam logic signed [GainWidth-1:0] RESET_TOP_FIN_GAIN = -16'sd4915;

   // servo: (angle * 41723 + 2^27) >> 20
   localparam logic signed [MulWidth-1:0] SERVO_MUL    = 22'sd41723;
   localparam logic signed [31:0]         SERVO_OFFSET = 32'sd134217728;
   // velocity: |thrust| * 32212 / 15360, done as (x >> 10) / 15
   localparam logic signed [MulWidth-1:0] VEL_MUL      = 22'sd32212;
   // ceil(2^24 / 15), exact for any 20-bit dividend
   localparam logic signed [MulWidth-1:0] DIV15_RECIP  = 22'sd1118482;

endpackage

>>> design/fin_thruster_command_arbiter_core.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  op, source, times, four angles, thrust
// rsp       out        rsp_valid / rsp_stall  four servo bytes, motor_velocity, failsafe
// csr       in         csr_valid / csr_ready  csr_index, csr_data
//
// A new item is taken only once the sequencer is back in idle; a failsafe word runs the kill
// step first, and an item that gives no word goes back to idle early. The sequencer walks one
// shared 22x22 multiplier and one 48-bit subtract/compare unit through the steps. Reset is
// synchronous and restores the register defaults and the remote mode with both stored
// times at zero. A finished word sits in the output register; if it is still stalled
// when the next one is ready, the sequencer holds in its last step and req_stall stays high.
module fin_thruster_command_arbiter_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_op,
   input  logic [1:0]                             req_source,
   input  logic [ftca_pkg::TimeWidth-1:0]         req_message_time,
   input  logic [ftca_pkg::TimeWidth-1:0]         req_now_time,
   input  logic signed [ftca_pkg::AngleWidth-1:0] req_top_angle,
   input  logic signed [ftca_pkg::AngleWidth-1:0] req_bottom_angle,
   input  logic signed [ftca_pkg::AngleWidth-1:0] req_port_angle,
   input  logic signed [ftca_pkg::AngleWidth-1:0] req_starboard_angle,
   input  logic signed [ftca_pkg::AngleWidth-1:0] req_thrust,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [7:0]                             rsp_top_byte,
   output logic [7:0]                             rsp_bottom_byte,
   output logic [7:0]                             rsp_port_byte,
   output logic [7:0]                             rsp_starboard_byte,
   output logic signed [ftca_pkg::VelWidth-1:0]   rsp_motor_velocity,
   output logic                                   rsp_failsafe,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ftca_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [ftca_pkg::RegWidth-1:0]          csr_data
);
   import ftca_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DECIDE    = 4'd1;
   localparam logic [3:0] S_KILL      = 4'd2;
   localparam logic [3:0] S_RATE      = 4'd3;
   localparam logic [3:0] S_MUL_TOP   = 4'd4;
   localparam logic [3:0] S_CLAMP     = 4'd5;
   localparam logic [3:0] S_SERVO_MUL = 4'd6;
   localparam logic [3:0] S_SERVO_GET = 4'd7;
   localparam logic [3:0] S_VEL_MAG   = 4'd8;
   localparam logic [3:0] S_VEL_DIV   = 4'd9;
   localparam logic [3:0] S_VEL_OUT   = 4'd10;

   function automatic logic signed [FinWidth-1:0] clamp_fin(
      input logic signed [AngleWidth-1:0] a,
      input logic [LimWidth-1:0]          lim
   );
      logic signed [AngleWidth:0] a_x;
      logic signed [AngleWidth:0] l_x;
      logic signed [AngleWidth:0] nl_x;
      a_x  = {a[AngleWidth-1], a};
      l_x  = {{(AngleWidth+1-LimWidth){1'b0}}, lim};
      nl_x = -l_x;
      if (a_x >= l_x) begin
         return l_x[FinWidth-1:0];
      end else if (a_x <= nl_x) begin
         return nl_x[FinWidth-1:0];
      end else begin
         return a_x[FinWidth-1:0];
      end
   endfunction

   // control state
   logic [3:0]                  state_ff, state_in;
   logic [1:0]                  mode_ff, mode_in;
   logic [1:0]                  idx_ff, idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [TimeWidth-1:0]        remote_time_ff, remote_time_in;
   logic [TimeWidth-1:0]        last_send_ff, last_send_in;
   logic [RegWidth-1:0]         timeout_ff, period_ff;
   logic [LimWidth-1:0]         lim_ff;
   logic signed [GainWidth-1:0] gain_ff;

   // item payload
   logic                         op_ff;
   logic [1:0]                   src_ff;
   logic [TimeWidth-1:0]         mtime_ff, now_ff;
   logic signed [AngleWidth-1:0] top_ff, bot_ff, port_ff, stbd_ff, thrust_ff;
   logic signed [AngleWidth-1:0] top_in, bot_in, port_in, stbd_in, thrust_in;
   logic                         fs_ff, fs_in;
   logic signed [FinWidth-1:0]   fin_ff [4];
   logic [7:0]                   byte_ff [4];
   logic signed [ProdWidth-1:0]  prod_ff;

   // output register
   logic [7:0]                   out_byte_ff [4];
   logic signed [VelWidth-1:0]   out_vel_ff;
   logic                         out_fs_ff;

   // shared units
   logic signed [MulWidth-1:0]   mul_a, mul_b;
   logic signed [ProdWidth-1:0]  prod_in;
   logic [TimeWidth-1:0]         sub_x, sub_y, sub_d;
   logic [RegWidth-1:0]          cmp_thr;
   logic                         over;

   logic                         req_take, rsp_take, out_load, is_top;
   logic signed [31:0]           p, lim_q, nlim_q, p_rnd, servo_sum;
   logic signed [FinWidth-1:0]   top_fin, lim_s;
   logic [AngleWidth:0]          thrust_mag;
   logic [16:0]                  quot;
   logic signed [VelWidth-1:0]   vel;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;
   assign out_load  = (state_ff == S_VEL_OUT) && (!rsp_valid_ff || !rsp_stall);

   // one 48-bit subtractor; signed difference strictly above the threshold
   always_comb begin
      sub_x   = now_ff;
      sub_y   = last_send_ff;
      cmp_thr = period_ff;
      unique case (state_ff)
         S_DECIDE: begin
            sub_y   = remote_time_ff;
            cmp_thr = timeout_ff;
         end
         S_KILL: begin
            sub_x = last_send_ff;
            sub_y = {{(TimeWidth-RegWidth){1'b0}}, period_ff};
         end
         default: ;
      endcase
      sub_d = sub_x - sub_y;
      over  = !sub_d[TimeWidth-1] &&
              (sub_d[TimeWidth-2:0] > {{(TimeWidth-1-RegWidth){1'b0}}, cmp_thr});
   end

   // one shared multiplier, product registered
   assign thrust_mag = thrust_ff[AngleWidth-1] ? -{thrust_ff[AngleWidth-1], thrust_ff}
                                               : {thrust_ff[AngleWidth-1], thrust_ff};
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MUL_TOP: begin
            mul_a = MulWidth'(top_ff);
            mul_b = MulWidth'(gain_ff);
         end
         S_SERVO_MUL: begin
            mul_a = MulWidth'(fin_ff[idx_ff]);
            mul_b = SERVO_MUL;
         end
         S_VEL_MAG: begin
            mul_a = {{(MulWidth-AngleWidth-1){1'b0}}, thrust_mag};
            mul_b = VEL_MUL;
         end
         S_VEL_DIV: begin
            mul_a = {2'b00, prod_ff[29:10]};
            mul_b = DIV15_RECIP;
         end
         default: ;
      endcase
      prod_in = mul_a * mul_b;
   end

   // top fin: clamp the product, else round half up out of Q20.12
   always_comb begin
      p      = prod_ff[31:0];
      lim_q  = {7'd0, lim_ff, 12'd0};
      nlim_q = -lim_q;
      p_rnd  = p + 32'sd2048;
      lim_s  = {1'b0, lim_ff};
      if (p >= lim_q) begin
         top_fin = lim_s;
      end else if (p <= nlim_q) begin
         top_fin = -lim_s;
      end else begin
         top_fin = p_rnd[25:12];
      end
   end

   assign servo_sum = prod_ff[31:0] + SERVO_OFFSET;
   assign is_top    = (idx_ff == 2'd0);
   assign quot      = prod_ff[40:24];
   assign vel       = (!thrust_ff[AngleWidth-1] && (thrust_ff != '0))
                      ? -$signed({8'd0, quot}) : $signed({8'd0, quot});

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      idx_in         = idx_ff;
      remote_time_in = remote_time_ff;
      last_send_in   = last_send_ff;
      fs_in          = fs_ff;
      top_in         = top_ff;
      bot_in         = bot_ff;
      port_in        = port_ff;
      stbd_in        = stbd_ff;
      thrust_in      = thrust_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_take;
      if (req_take) begin
         top_in    = req_top_angle;
         bot_in    = req_bottom_angle;
         port_in   = req_port_angle;
         stbd_in   = req_starboard_angle;
         thrust_in = req_thrust;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (op_ff == OP_TICK) begin
               state_in = S_IDLE;
               if (mode_ff == MODE_REMOTE && over) begin
                  // failsafe: zero command through the same datapath
                  mode_in   = MODE_DEAD;
                  fs_in     = 1'b1;
                  top_in    = '0;
                  bot_in    = '0;
                  port_in   = '0;
                  stbd_in   = '0;
                  thrust_in = '0;
                  state_in  = S_KILL;
               end
            end else begin
               fs_in    = 1'b0;
               state_in = S_RATE;
               if (src_ff == SRC_REMOTE) begin
                  remote_time_in = mtime_ff;
                  mode_in        = MODE_REMOTE;
               end
               if (src_ff == SRC_RELEASE) begin
                  mode_in = MODE_MISSION;
               end
               if (src_ff == SRC_AUTO && mode_ff != MODE_MISSION) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_KILL: begin
            last_send_in = sub_d;
            state_in     = S_RATE;
         end
         S_RATE: begin
            if (over) begin
               last_send_in = now_ff;
               state_in     = S_MUL_TOP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MUL_TOP: begin
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            idx_in   = 2'd0;
            state_in = S_SERVO_MUL;
         end
         S_SERVO_MUL: begin
            state_in = S_SERVO_GET;
         end
         S_SERVO_GET: begin
            idx_in   = idx_ff + 2'd1;
            state_in = (idx_ff == 2'd3) ? S_VEL_MAG : S_SERVO_MUL;
         end
         S_VEL_MAG: begin
            state_in = S_VEL_DIV;
         end
         S_VEL_DIV: begin
            state_in = S_VEL_OUT;
         end
         S_VEL_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         mode_ff        <= MODE_REMOTE;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         remote_time_ff <= '0;
         last_send_ff   <= '0;
         timeout_ff     <= RESET_REMOTE_TIMEOUT;
         period_ff      <= RESET_COMMAND_PERIOD;
         lim_ff         <= RESET_MAX_FIN_ANGLE;
         gain_ff        <= RESET_TOP_FIN_GAIN;
      end else begin
         state_ff       <= state_in;
         mode_ff        <= mode_in;
         idx_ff         <= idx_in;
         rsp_valid_ff   <= rsp_valid_in;
         remote_time_ff <= remote_time_in;
         last_send_ff   <= last_send_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_REMOTE_TIMEOUT: timeout_ff <= csr_data;
               REG_COMMAND_PERIOD: period_ff  <= csr_data;
               REG_MAX_FIN_ANGLE:  lim_ff     <= csr_data[LimWidth-1:0];
               REG_TOP_FIN_GAIN:   gain_ff    <= csr_data[GainWidth-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      // quotient stays put while the last step waits on the output register
      if (state_ff != S_VEL_OUT) begin
         prod_ff <= prod_in;
      end
      fs_ff     <= fs_in;
      top_ff    <= top_in;
      bot_ff    <= bot_in;
      port_ff   <= port_in;
      stbd_ff   <= stbd_in;
      thrust_ff <= thrust_in;
      if (req_take) begin
         op_ff    <= req_op;
         src_ff   <= req_source;
         mtime_ff <= req_message_time;
         now_ff   <= req_now_time;
      end
      if (state_ff == S_CLAMP) begin
         fin_ff[0] <= top_fin;
         fin_ff[1] <= clamp_fin(bot_ff, lim_ff);
         fin_ff[2] <= clamp_fin(port_ff, lim_ff);
         fin_ff[3] <= clamp_fin(stbd_ff, lim_ff);
      end
      if (state_ff == S_SERVO_GET) begin
         // top servo byte goes out negated
         byte_ff[idx_ff] <= is_top ? 8'(-servo_sum[27:20]) : servo_sum[27:20];
      end
      if (out_load) begin
         out_byte_ff[0] <= byte_ff[0];
         out_byte_ff[1] <= byte_ff[1];
         out_byte_ff[2] <= byte_ff[2];
         out_byte_ff[3] <= byte_ff[3];
         out_vel_ff     <= vel;
         out_fs_ff      <= fs_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_top_byte       = out_byte_ff[0];
   assign rsp_bottom_byte    = out_byte_ff[1];
   assign rsp_port_byte      = out_byte_ff[2];
   assign rsp_starboard_byte = out_byte_ff[3];
   assign rsp_motor_velocity = out_vel_ff;
   assign rsp_failsafe       = out_fs_ff;

endmodule

>>> test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ftca_pkg::*;

   localparam logic [1:0] SRC_OTHER = 2'd3;
   localparam longint SERVO_GAIN = 41723;
   localparam longint SERVO_BIAS = 134217728;
   localparam longint VEL_NUM = 32212;
   localparam longint VEL_DEN = 15360;
   localparam int SETTLE_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS = 90;

   typedef struct packed {
      logic                         op;
      logic [1:0]                   source;
      logic [TimeWidth-1:0]         message_time;
      logic [TimeWidth-1:0]         now_time;
      logic signed [AngleWidth-1:0] top_angle;
      logic signed [AngleWidth-1:0] bottom_angle;
      logic signed [AngleWidth-1:0] port_angle;
      logic signed [AngleWidth-1:0] starboard_angle;
      logic signed [AngleWidth-1:0] thrust;
   } arb_cmd_type;

   typedef struct packed {
      logic [7:0]                 top_byte;
      logic [7:0]                 bottom_byte;
      logic [7:0]                 port_byte;
      logic [7:0]                 starboard_byte;
      logic signed [VelWidth-1:0] motor_velocity;
      logic                       failsafe;
   } act_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_op = OP_COMMAND;
   logic [1:0]                   req_source = SRC_AUTO;
   logic [TimeWidth-1:0]         req_message_time = '0;
   logic [TimeWidth-1:0]         req_now_time = '0;
   logic signed [AngleWidth-1:0] req_top_angle = '0;
   logic signed [AngleWidth-1:0] req_bottom_angle = '0;
   logic signed [AngleWidth-1:0] req_port_angle = '0;
   logic signed [AngleWidth-1:0] req_starboard_angle = '0;
   logic signed [AngleWidth-1:0] req_thrust = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [7:0]                   rsp_top_byte;
   logic [7:0]                   rsp_bottom_byte;
   logic [7:0]                   rsp_port_byte;
   logic [7:0]                   rsp_starboard_byte;
   logic signed [VelWidth-1:0]   rsp_motor_velocity;
   logic                         rsp_failsafe;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CsrIdxWidth-1:0]       csr_index = REG_REMOTE_TIMEOUT;
   logic [RegWidth-1:0]          csr_data = '0;

   // predictor copy of the registers and the arbiter state
   logic [RegWidth-1:0]          cfg_timeout = RESET_REMOTE_TIMEOUT;
   logic [RegWidth-1:0]          cfg_period = RESET_COMMAND_PERIOD;
   logic [LimWidth-1:0]          cfg_limit = RESET_MAX_FIN_ANGLE;
   logic signed [GainWidth-1:0]  cfg_gain = RESET_TOP_FIN_GAIN;
   logic [1:0]                   arb_mode = MODE_REMOTE;
   logic [TimeWidth-1:0]         remote_stamp = '0;
   logic [TimeWidth-1:0]         last_sent = '0;

   act_word_type pending_words[$];
   logic [TimeWidth-1:0] clock_us = '0;
   bit idle_on = 1'b1;
   int mismatches = 0;
   int items_sent = 0;
   int words_checked = 0;
   int failsafe_words = 0;
   int settings_applied = 0;
   int stall_run = 0;
   int flow_run = 0;

   fin_thruster_command_arbiter_core DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit time_passed(input logic [TimeWidth-1:0] now,
                                      input logic [TimeWidth-1:0] then,
                                      input logic [RegWidth-1:0] thr);
      logic signed [TimeWidth-1:0] diff;
      longint d;
      diff = now - then;
      d = diff;
      return d > longint'({40'd0, thr});
   endfunction

   // bits 27:20 are the floor shift by 20, modulo 256
   function automatic logic [7:0] servo_byte(input longint angle);
      longint v;
      v = angle * SERVO_GAIN + SERVO_BIAS;
      return v[27:20];
   endfunction

   function automatic longint clamp_fin(input longint a, input longint lim);
      if (a >= lim) return lim;
      if (a <= -lim) return -lim;
      return a;
   endfunction

   function automatic bit emit_word(input logic [TimeWidth-1:0] now,
                                    input longint top, bot, port, stbd, thrust,
                                    input logic fs, output act_word_type w);
      longint vel;
      if (!time_passed(now, last_sent, cfg_period)) return 1'b0;
      last_sent = now;
      vel = (-thrust * VEL_NUM) / VEL_DEN;
      w.top_byte = 8'd0 - servo_byte(top);
      w.bottom_byte = servo_byte(bot);
      w.port_byte = servo_byte(port);
      w.starboard_byte = servo_byte(stbd);
      w.motor_velocity = vel[VelWidth-1:0];
      w.failsafe = fs;
      return 1'b1;
   endfunction

   function automatic bit predict_actuator_word(input arb_cmd_type c, output act_word_type w);
      longint lim, p, top;
      lim = cfg_limit;
      if (c.op == OP_TICK) begin
         if (arb_mode != MODE_REMOTE || !time_passed(c.now_time, remote_stamp, cfg_timeout))
            return 1'b0;
         arb_mode = MODE_DEAD;
         last_sent = last_sent - cfg_period;
         return emit_word(c.now_time, 0, 0, 0, 0, 0, 1'b1, w);
      end
      if (c.source == SRC_REMOTE) begin
         remote_stamp = c.message_time;
         arb_mode = MODE_REMOTE;
      end
      if (c.source == SRC_RELEASE) arb_mode = MODE_MISSION;
      if (c.source == SRC_AUTO && arb_mode != MODE_MISSION) return 1'b0;
      p = longint'(c.top_angle) * longint'(cfg_gain);
      if (p >= lim * 4096) top = lim;
      else if (p <= -lim * 4096) top = -lim;
      else top = (p + 2048) >>> 12;
      return emit_word(c.now_time, top, clamp_fin(c.bottom_angle, lim),
                       clamp_fin(c.port_angle, lim), clamp_fin(c.starboard_angle, lim),
                       c.thrust, 1'b0, w);
   endfunction

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic arb_cmd_type make_cmd(input logic op, input logic [1:0] src,
                                            input logic [TimeWidth-1:0] mtime, now,
                                            input logic signed [AngleWidth-1:0] top, bot,
                                            input logic signed [AngleWidth-1:0] port, stbd,
                                            input logic signed [AngleWidth-1:0] thrust);
      return '{op, src, mtime, now, top, bot, port, stbd, thrust};
   endfunction

   function automatic logic [TimeWidth-1:0] advance(input longint unsigned step);
      clock_us = clock_us + step;
      return clock_us;
   endfunction

   function automatic logic signed [AngleWidth-1:0] random_angle();
      int r, a, lim;
      lim = cfg_limit;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         a = int'($urandom_range(0, 2 * lim + 400)) - lim - 200;
         return a[AngleWidth-1:0];
      end
      if (r < 65) begin
         case ($urandom_range(0, 3))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return lim[AngleWidth-1:0];
            default: return -lim[AngleWidth-1:0];
         endcase
      end
      return 16'($urandom);
   endfunction

   function automatic arb_cmd_type random_cmd();
      arb_cmd_type c;
      int r;
      c.op = ($urandom_range(0, 99) < 20) ? OP_TICK : OP_COMMAND;
      r = $urandom_range(0, 99);
      c.source = r < 40 ? SRC_AUTO : r < 65 ? SRC_REMOTE : r < 80 ? SRC_RELEASE : SRC_OTHER;
      r = $urandom_range(0, 99);
      if (c.op == OP_TICK && r < 40) clock_us = clock_us + cfg_timeout + $urandom_range(1, 5000);
      else if (r < 70) clock_us = clock_us + cfg_period + $urandom_range(1, 50000);
      else if (r < 86) clock_us = clock_us + $urandom_range(0, cfg_period);
      else if (r < 95) clock_us = clock_us - $urandom_range(0, 2000);
      // far jump that still lands at or ahead of the last send
      else clock_us = last_sent + {1'b0, 47'({$urandom, $urandom})};
      c.now_time = clock_us;
      if ($urandom_range(0, 9) < 8) c.message_time = clock_us - $urandom_range(0, 1000);
      else c.message_time = 48'({$urandom, $urandom});
      c.top_angle = random_angle();
      c.bottom_angle = random_angle();
      c.port_angle = random_angle();
      c.starboard_angle = random_angle();
      c.thrust = 16'($urandom);
      return c;
   endfunction

   task automatic send_word(input arb_cmd_type c);
      int gap;
      act_word_type w;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= c.op;
      req_source <= c.source;
      req_message_time <= c.message_time;
      req_now_time <= c.now_time;
      req_top_angle <= c.top_angle;
      req_bottom_angle <= c.bottom_angle;
      req_port_angle <= c.port_angle;
      req_starboard_angle <= c.starboard_angle;
      req_thrust <= c.thrust;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      items_sent++;
      if (predict_actuator_word(c, w)) pending_words.push_back(w);
   endtask

   task automatic hold_until_drained(input bit settle);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      // commands that give no word may still be in flight
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx, input logic [RegWidth-1:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (idx)
         REG_REMOTE_TIMEOUT: cfg_timeout = data;
         REG_COMMAND_PERIOD: cfg_period = data;
         REG_MAX_FIN_ANGLE: cfg_limit = data[LimWidth-1:0];
         default: cfg_gain = data[GainWidth-1:0];
      endcase
   endtask

   task automatic set_config(input logic [RegWidth-1:0] timeout, period,
                             input logic [LimWidth-1:0] limit,
                             input logic signed [GainWidth-1:0] gain);
      hold_until_drained(1'b1);
      write_reg(REG_REMOTE_TIMEOUT, timeout);
      write_reg(REG_COMMAND_PERIOD, period);
      // upper data bits are junk the register must drop
      write_reg(REG_MAX_FIN_ANGLE, {11'($urandom), limit});
      write_reg(REG_TOP_FIN_GAIN, {8'($urandom), gain});
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   task automatic test_mode_arbitration();
      send_word(make_cmd(OP_COMMAND, SRC_AUTO, 0, 200000, 100, 100, 100, 100, 256));
      send_word(make_cmd(OP_COMMAND, SRC_OTHER, 0, 200000, 32767, 32767, 32767, 32767, 32767));
      // rate limited, but the remote stamp still moves
      send_word(make_cmd(OP_COMMAND, SRC_REMOTE, 250000, 250000, 0, 0, 0, 0, 0));
      send_word(make_cmd(OP_COMMAND, SRC_REMOTE, 300001, 300001,
                         -32768, -32768, -32768, -32768, -32768));
      send_word(make_cmd(OP_TICK, SRC_AUTO, 0, 2300001, 0, 0, 0, 0, 0));
      send_word(make_cmd(OP_TICK, SRC_RELEASE, '1, 2300002, 1234, -1234, 5, -5, 999));
      send_word(make_cmd(OP_COMMAND, SRC_AUTO, 0, 9100000, 7, 7, 7, 7, 7));
      send_word(make_cmd(OP_COMMAND, SRC_OTHER, 0, 9200000, 2859, -2859, 2858, -2858, 1));
      send_word(make_cmd(OP_COMMAND, SRC_RELEASE, 0, 9300001, 0, 0, 0, 0, -1));
      send_word(make_cmd(OP_COMMAND, SRC_AUTO, 0, 9400002, -100, 2860, -2860, 1000, 15360));
      send_word(make_cmd(OP_TICK, SRC_REMOTE, 0, 99000000, 0, 0, 0, 0, 0));
      // time running backwards never passes
      send_word(make_cmd(OP_COMMAND, SRC_AUTO, 0, 0, 1, 1, 1, 1, 1));
      send_word(make_cmd(OP_COMMAND, SRC_REMOTE, 48'hFFFF_FFFF_FC18, 9500003, 50, 60, 70, 80, 90));
      // stamp near the top wraps: stale, but the send window is behind
      send_word(make_cmd(OP_TICK, SRC_AUTO, 0, 2000001, 0, 0, 0, 0, 0));
      send_word(make_cmd(OP_COMMAND, SRC_OTHER, '1, '1, -1, -1, -1, -1, -1));
      send_word(make_cmd(OP_COMMAND, SRC_REMOTE, 9600004, 9600004, 2000, -2000, 3, -3, 12345));
   endtask

   task automatic test_rounding_and_limits();
      clock_us = last_sent;
      // unit gain: half-way products round up on both signs
      set_config(RESET_REMOTE_TIMEOUT, '0, 13'd6434, 16'sd1);
      send_word(make_cmd(OP_COMMAND, SRC_OTHER, 0, advance(1), 2048, 6434, -6434, 6435, 0));
      send_word(make_cmd(OP_COMMAND, SRC_OTHER, 0, advance(1), -2048, -6435, 100, -100, 1));
      send_word(make_cmd(OP_COMMAND, SRC_OTHER, 0, advance(1), -2049, 0, 0, 0, -1));
      send_word(make_cmd(OP_COMMAND, SRC_OTHER, 0, advance(0), 32767, 0, 0, 0, 0));
      // zero limit flattens every fin, zero timeout trips at once
      set_config('0, '0, '0, 16'sh8000);
      send_word(make_cmd(OP_COMMAND, SRC_REMOTE, 0, advance(1), -32768, 32767, -1, 1, 32767));
      send_word(make_cmd(OP_TICK, SRC_AUTO, '1, advance(1), 1, 1, 1, 1, 1));
      send_word(make_cmd(OP_TICK, SRC_REMOTE, '1, advance(5), 1, 1, 1, 1, 1));
      set_config('1, '1, 13'd6434, 16'sh7FFF);
      send_word(make_cmd(OP_COMMAND, SRC_RELEASE, 0, advance(64'h100_0000),
                         32767, -32768, 6434, -6434, -256));
      send_word(make_cmd(OP_COMMAND, SRC_AUTO, 0, advance(64'hFF_FFFF), 1, 2, 3, 4, 5));
      send_word(make_cmd(OP_COMMAND, SRC_AUTO, 0, advance(1), -1, -2, -3, -4, -5));
      send_word(make_cmd(OP_TICK, SRC_AUTO, 0, advance(100000000), 0, 0, 0, 0, 0));
   endtask

   task automatic test_random_phases();
      clock_us = last_sent;
      for (int ph = 0; ph < 7; ph++) begin
         idle_on = (ph != 1);
         case (ph)
            0: set_config(RESET_REMOTE_TIMEOUT, RESET_COMMAND_PERIOD,
                          RESET_MAX_FIN_ANGLE, RESET_TOP_FIN_GAIN);
            1, 5: set_config(24'($urandom), 24'($urandom),
                             13'($urandom_range(0, 6434)), 16'($urandom));
            2: set_config(24'($urandom_range(0, 3000)), 24'($urandom_range(0, 200)),
                          13'd6434, 16'($urandom));
            3: set_config('1, '1, 13'd6434, 16'sh7FFF);
            4: set_config('0, '0, '0, 16'sh8000);
            default: set_config(RESET_REMOTE_TIMEOUT, 24'($urandom_range(0, 100000)),
                                13'($urandom_range(0, 6434)), 16'($urandom));
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2) hold_until_drained(1'b0);
            send_word(random_cmd());
         end
      end
      idle_on = 1'b1;
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want, got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : word_check
      act_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_words.size() == 0) begin
            $error("actuator word with none expected: top_byte %0d", rsp_top_byte);
            mismatches++;
         end else begin
            want = pending_words.pop_front();
            check_field("top_byte", want.top_byte, rsp_top_byte);
            check_field("bottom_byte", want.bottom_byte, rsp_bottom_byte);
            check_field("port_byte", want.port_byte, rsp_port_byte);
            check_field("starboard_byte", want.starboard_byte, rsp_starboard_byte);
            check_field("motor_velocity", want.motor_velocity, rsp_motor_velocity);
            check_field("failsafe", want.failsafe, rsp_failsafe);
            words_checked++;
            if (want.failsafe) failsafe_words++;
         end
      end
   end

   // receiver back-pressure: a stall burst, then a run of open cycles
   always @(posedge clock) begin
      if (stall_run > 0) begin
         stall_run = stall_run - 1;
         rsp_stall <= 1'b1;
      end else if (flow_run > 0) begin
         flow_run = flow_run - 1;
         rsp_stall <= 1'b0;
      end else begin
         stall_run = pick_gap();
         flow_run = $urandom_range(1, 8);
         rsp_stall <= 1'b0;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
             (csr_valid === 1'b1 && csr_ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_mode_arbitration();
      test_rounding_and_limits();
      test_random_phases();
      hold_until_drained(1'b1);
      $display("summary: %0d commands and ticks, %0d actuator words checked (%0d failsafe)",
               items_sent, words_checked, failsafe_words);
      $display("summary: %0d register settings incl. zero and full-scale, %0d mismatches",
               settings_applied, mismatches);
      if (mismatches == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

>>> files.f
design/ftca_pkg.sv
design/fin_thruster_command_arbiter_core.sv
test/tb_top.sv
